### hw/rtl/lfl_pkg.sv
// Loop filter level and limit control: shared types, constants and helpers.
// No dependencies; used by the interfaces, the top level and the checker.
`default_nettype none

package lfl_pkg;

    // Design limits
    localparam int MAX_LEVEL    = 63;
    localparam int NUM_SEGMENTS = 4;

    // Field widths
    localparam int LVL_W   = 6;   // lf_level / base_level
    localparam int LIM_W   = 6;   // interior_limit
    localparam int EDGE_W  = 8;   // mb / sub edge limits
    localparam int HEV_W   = 2;
    localparam int SHP_W   = 3;
    localparam int LANE_W  = 7;   // one packed signed level or delta
    localparam int PACK_W  = 4 * LANE_W;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = PACK_W;
    localparam int SEG_W   = 2;

    // Internal level width: base + segment + ref + mode deltas, signed
    localparam int SUM_W   = LVL_W + 4;

    // Thresholds
    localparam int HEV_HI      = 40;
    localparam int HEV_MID     = 20;
    localparam int HEV_LO      = 15;
    localparam int LIM_CAP_TOP = 9;
    localparam int MB_EDGE_ADD = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BASE_LEVEL     = 3'd0,
        CFG_SHARPNESS      = 3'd1,
        CFG_FRAME_IS_KEY   = 3'd2,
        CFG_SEGMENT_MODE   = 3'd3,
        CFG_SEGMENT_VALUES = 3'd4,
        CFG_DELTA_ENABLE   = 3'd5,
        CFG_REF_DELTAS     = 3'd6,
        CFG_MODE_DELTAS    = 3'd7
    } t_cfg_reg;

    typedef enum logic [1:0] {
        SEG_OFF   = 2'd0,
        SEG_DELTA = 2'd1,
        SEG_ABS   = 2'd2,
        SEG_ABS_X = 2'd3    // unused encoding, treated as absolute
    } t_seg_mode;

    typedef enum logic [1:0] {
        MODE_OTHER = 2'd0,
        MODE_BPRED = 2'd1,
        MODE_ZERO  = 2'd2,
        MODE_SPLIT = 2'd3
    } t_mode_class;

    typedef enum logic [1:0] {
        MDL_BPRED = 2'd0,
        MDL_ZERO  = 2'd1,
        MDL_OTHER = 2'd2,
        MDL_SPLIT = 2'd3
    } t_mode_lane;

    localparam logic [1:0] REF_INTRA = 2'd0;

    // Signed 7-bit entry idx of a packed word
    function automatic logic signed [LANE_W-1:0] lane7(input logic [PACK_W-1:0] packed_w,
                                                       input logic [1:0] idx);
        lane7 = signed'(packed_w[LANE_W*idx +: LANE_W]);
    endfunction

    function automatic logic [LVL_W-1:0] clamp_level(input logic signed [SUM_W-1:0] v);
        logic [LVL_W-1:0] res;
        if (v < 0) begin
            res = '0;
        end else if (v > SUM_W'(MAX_LEVEL)) begin
            res = LVL_W'(MAX_LEVEL);
        end else begin
            res = v[LVL_W-1:0];
        end
        clamp_level = res;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/lfl_if.sv
// Valid/ready channel interfaces: macroblock descriptor in, filter parameters out.
// Depends on lfl_pkg for field widths.
`default_nettype none

interface lfl_mb_if;
    logic                     valid;
    logic                     ready;
    logic [lfl_pkg::SEG_W-1:0] mb_segment;
    logic [1:0]               ref_idx;
    logic [1:0]               mode_class;
    logic                     has_coeffs;
    logic                     not_first_col;
    logic                     not_first_row;

    modport source (output valid, mb_segment, ref_idx, mode_class, has_coeffs,
                           not_first_col, not_first_row,
                    input  ready);
    modport sink   (input  valid, mb_segment, ref_idx, mode_class, has_coeffs,
                           not_first_col, not_first_row,
                    output ready);
endinterface

interface lfl_res_if;
    logic                       valid;
    logic                       ready;
    logic [lfl_pkg::LVL_W-1:0]  lf_level;
    logic [lfl_pkg::LIM_W-1:0]  interior_limit;
    logic [lfl_pkg::EDGE_W-1:0] mb_edge_limit;
    logic [lfl_pkg::EDGE_W-1:0] sub_edge_limit;
    logic [lfl_pkg::HEV_W-1:0]  hev_threshold;
    logic                       filter_left_edge;
    logic                       filter_top_edge;
    logic                       filter_inner_edges;

    modport source (output valid, lf_level, interior_limit, mb_edge_limit,
                           sub_edge_limit, hev_threshold, filter_left_edge,
                           filter_top_edge, filter_inner_edges,
                    input  ready);
    modport sink   (input  valid, lf_level, interior_limit, mb_edge_limit,
                           sub_edge_limit, hev_threshold, filter_left_edge,
                           filter_top_edge, filter_inner_edges,
                    output ready);
endinterface

`default_nettype wire

### hw/rtl/loop_filter_level_and_limit_control.sv
// Loop filter level and limit control, top level.
// Pipeline: input register -> result register.
// Throughput: one macroblock per cycle; both stages advance together when the
// result register is free or being taken, so a stall backs up one stage at a time.
// Reset (sync, active low): pipeline empty; config regs to defaults (key frame = 1).
// Depends on lfl_pkg and lfl_if.
`default_nettype none

module loop_filter_level_and_limit_control (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_cfg_wr_en,
    input  wire [lfl_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire [lfl_pkg::CFG_DAT_W-1:0]     i_cfg_wdata,
    lfl_mb_if.sink                           i_mb,
    lfl_res_if.source                        o_res
);

    // Configuration registers
    logic [lfl_pkg::LVL_W-1:0]  r_base_level;
    logic [lfl_pkg::SHP_W-1:0]  r_sharpness;
    logic                       r_frame_is_key;
    logic [1:0]                 r_segment_mode;
    logic [lfl_pkg::PACK_W-1:0] r_segment_values;
    logic                       r_delta_enable;
    logic [lfl_pkg::PACK_W-1:0] r_ref_deltas;
    logic [lfl_pkg::PACK_W-1:0] r_mode_deltas;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_level     <= '0;
            r_sharpness      <= '0;
            r_frame_is_key   <= 1'b1;
            r_segment_mode   <= '0;
            r_segment_values <= '0;
            r_delta_enable   <= 1'b0;
            r_ref_deltas     <= '0;
            r_mode_deltas    <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (lfl_pkg::t_cfg_reg'(i_cfg_index))
                lfl_pkg::CFG_BASE_LEVEL:     r_base_level     <= i_cfg_wdata[lfl_pkg::LVL_W-1:0];
                lfl_pkg::CFG_SHARPNESS:      r_sharpness      <= i_cfg_wdata[lfl_pkg::SHP_W-1:0];
                lfl_pkg::CFG_FRAME_IS_KEY:   r_frame_is_key   <= i_cfg_wdata[0];
                lfl_pkg::CFG_SEGMENT_MODE:   r_segment_mode   <= i_cfg_wdata[1:0];
                lfl_pkg::CFG_SEGMENT_VALUES: r_segment_values <= i_cfg_wdata[lfl_pkg::PACK_W-1:0];
                lfl_pkg::CFG_DELTA_ENABLE:   r_delta_enable   <= i_cfg_wdata[0];
                lfl_pkg::CFG_REF_DELTAS:     r_ref_deltas     <= i_cfg_wdata[lfl_pkg::PACK_W-1:0];
                lfl_pkg::CFG_MODE_DELTAS:    r_mode_deltas    <= i_cfg_wdata[lfl_pkg::PACK_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Pipeline control
    logic r_s1_valid;
    logic r_o_valid;
    logic adv_out;
    logic adv_s1;

    assign adv_out    = !r_o_valid || o_res.ready;
    assign i_mb.ready = !r_s1_valid || adv_out;
    assign adv_s1     = i_mb.valid && i_mb.ready;

    // Input register
    logic [lfl_pkg::SEG_W-1:0] r_s1_seg;
    logic [1:0]                r_s1_ref;
    logic [1:0]                r_s1_mode;
    logic                      r_s1_coeffs;
    logic                      r_s1_col_ok;
    logic                      r_s1_row_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_mb.ready) begin
            r_s1_valid <= i_mb.valid;
        end
        if (adv_s1) begin
            r_s1_seg    <= i_mb.mb_segment;
            r_s1_ref    <= i_mb.ref_idx;
            r_s1_mode   <= i_mb.mode_class;
            r_s1_coeffs <= i_mb.has_coeffs;
            r_s1_col_ok <= i_mb.not_first_col;
            r_s1_row_ok <= i_mb.not_first_row;
        end
    end

    // Level computation
    logic [lfl_pkg::SEG_W-1:0]        seg_sel;
    logic [1:0]                       md_lane;
    logic signed [lfl_pkg::SUM_W-1:0] base_ext;
    logic signed [lfl_pkg::SUM_W-1:0] seg_val;
    logic signed [lfl_pkg::SUM_W-1:0] delta_sum;
    logic [lfl_pkg::LVL_W-1:0]        seg_level;
    logic [lfl_pkg::LVL_W-1:0]        n_level;
    logic [lfl_pkg::LIM_W-1:0]        n_lim;
    logic [3:0]                       lim_cap;
    logic [lfl_pkg::EDGE_W-1:0]       lvl_x2;
    logic [lfl_pkg::EDGE_W-1:0]       n_mb_edge;
    logic [lfl_pkg::EDGE_W-1:0]       n_sub_edge;
    logic [lfl_pkg::HEV_W-1:0]        n_hev;
    logic                             lvl_on;

    always_comb begin
        // out-of-range segment ids fall back to segment 0
        seg_sel = ({1'b0, r_s1_seg} >= (lfl_pkg::SEG_W+1)'(lfl_pkg::NUM_SEGMENTS)) ?
                  '0 : r_s1_seg;
        base_ext = signed'(lfl_pkg::SUM_W'(r_base_level));
        seg_val  = lfl_pkg::SUM_W'(lfl_pkg::lane7(r_segment_values, seg_sel));

        priority if (r_segment_mode == lfl_pkg::SEG_OFF) begin
            seg_level = r_base_level;
        end else if (r_segment_mode == lfl_pkg::SEG_DELTA) begin
            seg_level = lfl_pkg::clamp_level(base_ext + seg_val);
        end else begin
            seg_level = lfl_pkg::clamp_level(seg_val);
        end

        // intra only takes the bpred mode delta; inter bpred maps to other
        if (r_s1_ref == lfl_pkg::REF_INTRA) begin
            md_lane = lfl_pkg::MDL_BPRED;
        end else begin
            unique case (lfl_pkg::t_mode_class'(r_s1_mode))
                lfl_pkg::MODE_ZERO:  md_lane = lfl_pkg::MDL_ZERO;
                lfl_pkg::MODE_SPLIT: md_lane = lfl_pkg::MDL_SPLIT;
                default:             md_lane = lfl_pkg::MDL_OTHER;
            endcase
        end

        delta_sum = signed'(lfl_pkg::SUM_W'(seg_level))
                  + lfl_pkg::SUM_W'(lfl_pkg::lane7(r_ref_deltas, r_s1_ref));
        if (r_s1_ref != lfl_pkg::REF_INTRA || r_s1_mode == lfl_pkg::MODE_BPRED) begin
            delta_sum = delta_sum + lfl_pkg::SUM_W'(lfl_pkg::lane7(r_mode_deltas, md_lane));
        end

        n_level = r_delta_enable ? lfl_pkg::clamp_level(delta_sum) : seg_level;

        // Interior limit
        n_lim = lfl_pkg::LIM_W'(n_level);
        if (r_sharpness != '0) begin
            n_lim = n_lim >> 1;
        end
        if (r_sharpness > lfl_pkg::SHP_W'(4)) begin
            n_lim = n_lim >> 1;
        end
        lim_cap = 4'(lfl_pkg::LIM_CAP_TOP) - {1'b0, r_sharpness};
        if (r_sharpness != '0 && n_lim > lfl_pkg::LIM_W'(lim_cap)) begin
            n_lim = lfl_pkg::LIM_W'(lim_cap);
        end
        if (n_lim == '0) begin
            n_lim = lfl_pkg::LIM_W'(1);
        end

        lvl_x2     = lfl_pkg::EDGE_W'({n_level, 1'b0});
        n_sub_edge = lvl_x2 + lfl_pkg::EDGE_W'(n_lim);
        n_mb_edge  = n_sub_edge + lfl_pkg::EDGE_W'(2 * lfl_pkg::MB_EDGE_ADD);

        // HEV threshold
        if (n_level >= lfl_pkg::LVL_W'(lfl_pkg::HEV_HI)) begin
            n_hev = r_frame_is_key ? 2'd2 : 2'd3;
        end else if (!r_frame_is_key && n_level >= lfl_pkg::LVL_W'(lfl_pkg::HEV_MID)) begin
            n_hev = 2'd2;
        end else if (n_level >= lfl_pkg::LVL_W'(lfl_pkg::HEV_LO)) begin
            n_hev = 2'd1;
        end else begin
            n_hev = 2'd0;
        end

        lvl_on = (n_level != '0);
    end

    // Result register
    logic [lfl_pkg::LVL_W-1:0]  r_o_level;
    logic [lfl_pkg::LIM_W-1:0]  r_o_lim;
    logic [lfl_pkg::EDGE_W-1:0] r_o_mb_edge;
    logic [lfl_pkg::EDGE_W-1:0] r_o_sub_edge;
    logic [lfl_pkg::HEV_W-1:0]  r_o_hev;
    logic                       r_o_left;
    logic                       r_o_top;
    logic                       r_o_inner;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (adv_out) begin
            r_o_valid <= r_s1_valid;
        end
        if (adv_out && r_s1_valid) begin
            r_o_level    <= n_level;
            r_o_lim      <= n_lim;
            r_o_mb_edge  <= n_mb_edge;
            r_o_sub_edge <= n_sub_edge;
            r_o_hev      <= n_hev;
            r_o_left     <= lvl_on && r_s1_col_ok;
            r_o_top      <= lvl_on && r_s1_row_ok;
            r_o_inner    <= lvl_on && r_s1_coeffs;
        end
    end

    assign o_res.valid              = r_o_valid;
    assign o_res.lf_level           = r_o_level;
    assign o_res.interior_limit     = r_o_lim;
    assign o_res.mb_edge_limit      = r_o_mb_edge;
    assign o_res.sub_edge_limit     = r_o_sub_edge;
    assign o_res.hev_threshold      = r_o_hev;
    assign o_res.filter_left_edge   = r_o_left;
    assign o_res.filter_top_edge    = r_o_top;
    assign o_res.filter_inner_edges = r_o_inner;

endmodule

`default_nettype wire

### hw/rtl/lfl_checker.sv
// Port-level checks for loop_filter_level_and_limit_control, bound to the top level.
// Depends on lfl_pkg for field widths.
`default_nettype none

module lfl_checker (
    input wire                         i_clk,
    input wire                         i_rst_n,
    input wire                         i_out_valid,
    input wire                         i_out_ready,
    input wire [lfl_pkg::LVL_W-1:0]    i_level,
    input wire [lfl_pkg::LIM_W-1:0]    i_lim,
    input wire [lfl_pkg::EDGE_W-1:0]   i_mb_edge,
    input wire [lfl_pkg::EDGE_W-1:0]   i_sub_edge,
    input wire                         i_left,
    input wire                         i_top,
    input wire                         i_inner
);

    // Pipeline comes out of reset empty
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    // Stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("result dropped while stalled");

    // Level zero disables every edge
    a_zero_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_level == '0) |-> (!i_left && !i_top && !i_inner))
        else $error("edge enabled at level zero");

    // MB edge limit exceeds sub-block limit by exactly four
    a_edge_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_mb_edge == i_sub_edge + lfl_pkg::EDGE_W'(4)))
        else $error("edge limit mismatch");

    // Interior limit never below one
    a_lim_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_lim != '0))
        else $error("interior limit zero");

endmodule

bind loop_filter_level_and_limit_control lfl_checker u_lfl_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_out_valid(o_res.valid),
    .i_out_ready(o_res.ready),
    .i_level    (o_res.lf_level),
    .i_lim      (o_res.interior_limit),
    .i_mb_edge  (o_res.mb_edge_limit),
    .i_sub_edge (o_res.sub_edge_limit),
    .i_left     (o_res.filter_left_edge),
    .i_top      (o_res.filter_top_edge),
    .i_inner    (o_res.filter_inner_edges)
);

`default_nettype wire

### tb/sv/tb_loop_filter_level_and_limit_control.sv
`timescale 1ns / 1ps
// Testbench for loop_filter_level_and_limit_control: a directed and a random run of macroblock
// descriptors checked against a built-in level/limit predictor. Depends on lfl_pkg and lfl_if.

module tb_loop_filter_level_and_limit_control;
    import lfl_pkg::*;

    localparam int ITEMS_PER_PHASE = 118;
    localparam int RANDOM_PHASES   = 10;
    localparam int LONG_HOLD       = 100;
    localparam int STUCK_LIMIT     = 3000;

    typedef struct packed {
        logic [SEG_W-1:0] mb_segment;
        logic [1:0]       ref_idx;
        logic [1:0]       mode_class;
        logic             has_coeffs;
        logic             not_first_col;
        logic             not_first_row;
    } mb_desc_t;

    typedef struct packed {
        logic [LVL_W-1:0]  lf_level;
        logic [LIM_W-1:0]  interior_limit;
        logic [EDGE_W-1:0] mb_edge_limit;
        logic [EDGE_W-1:0] sub_edge_limit;
        logic [HEV_W-1:0]  hev_threshold;
        logic              filter_left_edge;
        logic              filter_top_edge;
        logic              filter_inner_edges;
    } filter_params_t;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DAT_W-1:0] cfg_wdata;

    lfl_mb_if  mb_ch();
    lfl_res_if res_ch();

    loop_filter_level_and_limit_control dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (cfg_wr_en),
        .i_cfg_index (cfg_index),
        .i_cfg_wdata (cfg_wdata),
        .i_mb        (mb_ch),
        .o_res       (res_ch)
    );

    // Register shadow used by the predictor
    logic [LVL_W-1:0]  base_level_q;
    logic [SHP_W-1:0]  sharpness_q;
    logic              key_frame_q;
    t_seg_mode         seg_mode_q;
    logic [PACK_W-1:0] seg_values_q;
    logic              delta_en_q;
    logic [PACK_W-1:0] ref_deltas_q;
    logic [PACK_W-1:0] mode_deltas_q;

    mb_desc_t       pending_mbs[$];
    filter_params_t expected_params[$];

    int   mismatches;
    logic mb_taken;
    int   burst_left;
    int   gap_left;
    int   holds_requested;
    int   holds_served;
    int   hold_left;
    int   rx_cycle;
    int   stall_pct;
    int   stuck_cycles;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    function automatic int lane_of(logic [PACK_W-1:0] packed_w, int idx);
        int v;
        v = packed_w[LANE_W*idx +: LANE_W];
        if (v >= (1 << (LANE_W - 1))) v -= (1 << LANE_W);
        return v;
    endfunction

    function automatic int clamp_to_level(int v);
        if (v < 0) return 0;
        if (v > MAX_LEVEL) return MAX_LEVEL;
        return v;
    endfunction

    function automatic logic [PACK_W-1:0] pack_lanes(int l0, int l1, int l2, int l3);
        return {LANE_W'(l3), LANE_W'(l2), LANE_W'(l1), LANE_W'(l0)};
    endfunction

    // Narrow lanes keep levels away from the clamps; wide ones hit them often.
    function automatic logic [PACK_W-1:0] random_lanes(bit narrow);
        if (narrow)
            return pack_lanes($urandom_range(0, 16) - 8, $urandom_range(0, 16) - 8,
                              $urandom_range(0, 16) - 8, $urandom_range(0, 16) - 8);
        return PACK_W'($urandom);
    endfunction

    function automatic filter_params_t predict_filter_params(mb_desc_t mb);
        filter_params_t r;
        int seg;
        int lvl;
        int lim;
        int sh;
        seg = mb.mb_segment;
        if (seg >= NUM_SEGMENTS) seg = 0;
        case (seg_mode_q)
            SEG_OFF:   lvl = base_level_q;
            SEG_DELTA: lvl = clamp_to_level(int'(base_level_q) + lane_of(seg_values_q, seg));
            default:   lvl = clamp_to_level(lane_of(seg_values_q, seg));
        endcase
        if (delta_en_q) begin
            lvl += lane_of(ref_deltas_q, mb.ref_idx);
            if (mb.ref_idx == REF_INTRA) begin
                // intra only picks up the bpred delta
                if (mb.mode_class == MODE_BPRED) lvl += lane_of(mode_deltas_q, MDL_BPRED);
            end else if (mb.mode_class == MODE_ZERO) begin
                lvl += lane_of(mode_deltas_q, MDL_ZERO);
            end else if (mb.mode_class == MODE_SPLIT) begin
                lvl += lane_of(mode_deltas_q, MDL_SPLIT);
            end else begin
                lvl += lane_of(mode_deltas_q, MDL_OTHER);
            end
            lvl = clamp_to_level(lvl);
        end
        sh  = sharpness_q;
        lim = lvl;
        if (sh > 0) lim = lim >> 1;
        if (sh > 4) lim = lim >> 1;
        if (sh > 0 && lim > LIM_CAP_TOP - sh) lim = LIM_CAP_TOP - sh;
        if (lim < 1) lim = 1;
        if (key_frame_q)
            r.hev_threshold = (lvl >= HEV_HI) ? 2 : (lvl >= HEV_LO) ? 1 : 0;
        else
            r.hev_threshold = (lvl >= HEV_HI) ? 3 : (lvl >= HEV_MID) ? 2 :
                              (lvl >= HEV_LO) ? 1 : 0;
        r.lf_level           = LVL_W'(lvl);
        r.interior_limit     = LIM_W'(lim);
        r.mb_edge_limit      = EDGE_W'((lvl + MB_EDGE_ADD) * 2 + lim);
        r.sub_edge_limit     = EDGE_W'(lvl * 2 + lim);
        r.filter_left_edge   = (lvl != 0) && mb.not_first_col;
        r.filter_top_edge    = (lvl != 0) && mb.not_first_row;
        r.filter_inner_edges = (lvl != 0) && mb.has_coeffs;
        return r;
    endfunction

    task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    // Config writes happen only with the pipeline drained.
    task automatic write_reg(t_cfg_reg idx, logic [CFG_DAT_W-1:0] value);
        @(negedge i_clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(negedge i_clk);
        cfg_wr_en <= 1'b0;
        case (idx)
            CFG_BASE_LEVEL:     base_level_q  = value[LVL_W-1:0];
            CFG_SHARPNESS:      sharpness_q   = value[SHP_W-1:0];
            CFG_FRAME_IS_KEY:   key_frame_q   = value[0];
            CFG_SEGMENT_MODE:   seg_mode_q    = t_seg_mode'(value[1:0]);
            CFG_SEGMENT_VALUES: seg_values_q  = value[PACK_W-1:0];
            CFG_DELTA_ENABLE:   delta_en_q    = value[0];
            CFG_REF_DELTAS:     ref_deltas_q  = value[PACK_W-1:0];
            CFG_MODE_DELTAS:    mode_deltas_q = value[PACK_W-1:0];
        endcase
    endtask

    task automatic write_frame_setup(int base, int sharp, bit key, t_seg_mode smode,
                                     logic [PACK_W-1:0] segv, bit den,
                                     logic [PACK_W-1:0] refd, logic [PACK_W-1:0] moded);
        write_reg(CFG_BASE_LEVEL, base);
        write_reg(CFG_SHARPNESS, sharp);
        write_reg(CFG_FRAME_IS_KEY, key);
        write_reg(CFG_SEGMENT_MODE, smode);
        write_reg(CFG_SEGMENT_VALUES, segv);
        write_reg(CFG_DELTA_ENABLE, den);
        write_reg(CFG_REF_DELTAS, refd);
        write_reg(CFG_MODE_DELTAS, moded);
    endtask

    task automatic push_mb(int seg, int rf, int mode, bit coeffs, bit col, bit row);
        mb_desc_t m;
        m.mb_segment    = SEG_W'(seg);
        m.ref_idx       = 2'(rf);
        m.mode_class    = 2'(mode);
        m.has_coeffs    = coeffs;
        m.not_first_col = col;
        m.not_first_row = row;
        pending_mbs.push_back(m);
    endtask

    task automatic queue_random_mbs(int n);
        @(posedge i_clk);
        repeat (n)
            push_mb($urandom_range(0, 3), $urandom_range(0, 3), $urandom_range(0, 3),
                    $urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 1));
    endtask

    task automatic wait_drained();
        while (pending_mbs.size() != 0 || expected_params.size() != 0)
            @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    // Sender: bursts of transfers separated by random gaps
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            mb_ch.valid <= 1'b0;
        end else if (mb_ch.valid && !mb_taken) begin
            // hold the offered item until it transfers
        end else if (gap_left > 0) begin
            gap_left--;
            mb_ch.valid <= 1'b0;
        end else if (pending_mbs.size() != 0) begin
            mb_ch.valid         <= 1'b1;
            mb_ch.mb_segment    <= pending_mbs[0].mb_segment;
            mb_ch.ref_idx       <= pending_mbs[0].ref_idx;
            mb_ch.mode_class    <= pending_mbs[0].mode_class;
            mb_ch.has_coeffs    <= pending_mbs[0].has_coeffs;
            mb_ch.not_first_col <= pending_mbs[0].not_first_col;
            mb_ch.not_first_row <= pending_mbs[0].not_first_row;
            if (burst_left > 0) begin
                burst_left--;
            end else begin
                burst_left = $urandom_range(0, 30);
                gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            end
        end else begin
            mb_ch.valid <= 1'b0;
        end
    end

    // Receiver: random stalls at a rate that is redrawn over the run; long hold-off on request
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else if (holds_served != holds_requested) begin
            holds_served++;
            hold_left = LONG_HOLD;
            res_ch.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            res_ch.ready <= 1'b0;
        end else begin
            rx_cycle++;
            if (rx_cycle % 50 == 0) begin
                case ($urandom_range(0, 3))
                    0: stall_pct = 0;
                    1: stall_pct = 20;
                    2: stall_pct = 50;
                    default: stall_pct = 85;
                endcase
            end
            res_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin
        mb_desc_t       seen;
        filter_params_t want;
        if (!i_rst_n) begin
            mb_taken <= 1'b0;
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                if (expected_params.size() == 0) begin
                    $error("result transfer with no expected result pending");
                    mismatches++;
                end else begin
                    want = expected_params.pop_front();
                    check_field("lf_level", want.lf_level, res_ch.lf_level);
                    check_field("interior_limit", want.interior_limit, res_ch.interior_limit);
                    check_field("mb_edge_limit", want.mb_edge_limit, res_ch.mb_edge_limit);
                    check_field("sub_edge_limit", want.sub_edge_limit, res_ch.sub_edge_limit);
                    check_field("hev_threshold", want.hev_threshold, res_ch.hev_threshold);
                    check_field("filter_left_edge", want.filter_left_edge,
                                res_ch.filter_left_edge);
                    check_field("filter_top_edge", want.filter_top_edge,
                                res_ch.filter_top_edge);
                    check_field("filter_inner_edges", want.filter_inner_edges,
                                res_ch.filter_inner_edges);
                end
            end
            if (mb_ch.valid && mb_ch.ready) begin
                seen = pending_mbs.pop_front();
                expected_params.push_back(predict_filter_params(seen));
            end
            mb_taken <= mb_ch.valid && mb_ch.ready;
        end
    end

    // Watchdog: too long without any transfer or config write
    always @(posedge i_clk) begin
        if (!i_rst_n || cfg_wr_en || (mb_ch.valid && mb_ch.ready) ||
            (res_ch.valid && res_ch.ready)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles >= STUCK_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    initial begin
        bit narrow;
        i_rst_n             = 1'b0;
        cfg_wr_en           = 1'b0;
        cfg_index           = '0;
        cfg_wdata           = '0;
        mb_ch.valid         = 1'b0;
        mb_ch.mb_segment    = '0;
        mb_ch.ref_idx       = '0;
        mb_ch.mode_class    = '0;
        mb_ch.has_coeffs    = 1'b0;
        mb_ch.not_first_col = 1'b0;
        mb_ch.not_first_row = 1'b0;
        res_ch.ready        = 1'b0;
        mismatches          = 0;
        mb_taken            = 1'b0;
        burst_left          = 0;
        gap_left            = 0;
        holds_requested     = 0;
        holds_served        = 0;
        hold_left           = 0;
        rx_cycle            = 0;
        stall_pct           = 0;
        stuck_cycles        = 0;
        // reset values of the register file
        base_level_q  = '0;
        sharpness_q   = '0;
        key_frame_q   = 1'b1;
        seg_mode_q    = SEG_OFF;
        seg_values_q  = '0;
        delta_en_q    = 1'b0;
        ref_deltas_q  = '0;
        mode_deltas_q = '0;

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // defaults: level zero, all edges off
        queue_random_mbs(0);
        push_mb(0, 0, 0, 0, 0, 0);
        push_mb(3, 3, 3, 1, 1, 1);
        wait_drained();

        // top level, strongest sharpness, inter frame
        write_reg(CFG_BASE_LEVEL, MAX_LEVEL);
        write_reg(CFG_SHARPNESS, {SHP_W{1'b1}});
        write_reg(CFG_FRAME_IS_KEY, 0);
        @(posedge i_clk);
        push_mb(0, 1, 2, 1, 1, 1);
        push_mb(2, 2, 1, 0, 0, 0);
        wait_drained();

        // segment deltas at both lane extremes
        write_reg(CFG_BASE_LEVEL, 32);
        write_reg(CFG_SEGMENT_MODE, SEG_DELTA);
        write_reg(CFG_SEGMENT_VALUES, pack_lanes(-64, 63, 1, -1));
        @(posedge i_clk);
        for (int s = 0; s < 4; s++) push_mb(s, 0, 0, 1, 1, 1);
        wait_drained();

        // absolute segment levels, then the spare encoding that acts the same
        write_reg(CFG_SEGMENT_MODE, SEG_ABS);
        @(posedge i_clk);
        for (int s = 0; s < 4; s++) push_mb(s, 1, 0, 1, 0, 1);
        wait_drained();
        write_reg(CFG_SEGMENT_MODE, SEG_ABS_X);
        @(posedge i_clk);
        push_mb(1, 2, 2, 1, 1, 0);
        push_mb(2, 3, 3, 0, 1, 1);
        wait_drained();

        // reference and mode deltas over every intra/inter and mode pairing
        write_reg(CFG_SEGMENT_MODE, SEG_OFF);
        write_reg(CFG_BASE_LEVEL, 30);
        write_reg(CFG_SHARPNESS, 4);
        write_reg(CFG_DELTA_ENABLE, 1);
        write_reg(CFG_REF_DELTAS, pack_lanes(5, -3, 10, -20));
        write_reg(CFG_MODE_DELTAS, pack_lanes(4, -6, 8, -10));
        @(posedge i_clk);
        for (int m = 0; m < 4; m++) push_mb(0, 0, m, 1, 1, 1);
        for (int m = 0; m < 4; m++) push_mb(1, 1, m, 1, 1, 1);
        push_mb(2, 2, 1, 1, 1, 1);
        push_mb(3, 3, 3, 1, 1, 1);
        wait_drained();

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            if (ph == 0) begin
                write_frame_setup(0, 0, 0, SEG_OFF, '0, 0, '0, '0);
            end else if (ph == 1) begin
                write_frame_setup(MAX_LEVEL, {SHP_W{1'b1}}, 1, SEG_ABS_X, '1, 1, '1, '1);
            end else begin
                narrow = $urandom_range(0, 1);
                write_frame_setup($urandom_range(0, MAX_LEVEL), $urandom_range(0, 7),
                                  $urandom_range(0, 1), t_seg_mode'($urandom_range(0, 3)),
                                  random_lanes(narrow), $urandom_range(0, 1),
                                  random_lanes(narrow), random_lanes(narrow));
            end
            queue_random_mbs(ITEMS_PER_PHASE);
            // starve the output so the pipeline fills and backs up the input
            if (ph == 3 || ph == 7) holds_requested++;
            wait_drained();
        end

        repeat (8) @(posedge i_clk);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
